@@ sv/akst_pkg.sv @@
// shared types and constants for the aging keyed spot table
// no dependencies
`default_nettype none

package akst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [31:0] TTL_RESET = 32'd86400;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DUMP   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] heard;
        logic [31:0] freq;
        logic [7:0]  snr;
        logic [63:0] mode;
        logic        pos;
        logic [47:0] grid;
        logic [31:0] lat;
        logic [31:0] lon;
    } rec_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift;  // every cell takes its right neighbor
        logic write;  // the selected cell loads the write record instead
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/akst_cell.sv @@
// one table slot: holds a record, loads the write record or its right neighbor
// depends on akst_pkg
`default_nettype none

module akst_cell
    import akst_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_cmd_t cmd,
    input  wire logic      sel,
    input  wire rec_t      wr_rec,
    input  wire rec_t      nb_rec,
    output rec_t           rec
);

    rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write && sel)
            rec_reg <= wr_rec;
        else if (cmd.shift)
            rec_reg <= nb_rec;
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

@@ sv/aging_keyed_spot_table.sv @@
// top level of the aging keyed spot table: cell row plus sequencer
// depends on akst_pkg and akst_cell
`default_nettype none

// Records sit in a row of CAPACITY cells that shift one place toward cell 0;
// the held records occupy cells 0..count-1 and the sequencer sees only cell 0.
// An add or dump first takes one step per held record: the head record is
// judged for age and either goes back in at the end of the held part or is
// dropped, so survivors stay in order; the same pass finds the matching key
// and the oldest record. A decision step follows. An add then writes its
// slot in S_WRITE and returns to idle. A dump takes one more step per held
// record to bring the row back to order, emitting the first min(count, limit)
// records on those steps; each emitting step waits while the output register
// is stalled. With nothing to emit it sends one empty marker. Clear and the
// unused op leave the sequencer idle.
module aging_keyed_spot_table
    import akst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] key_high,
    input  wire logic [63:0] key_low,
    input  wire logic [31:0] now_time,
    input  wire logic [31:0] freq_hz,
    input  wire logic signed [7:0] snr_db,
    input  wire logic [63:0] mode_text,
    input  wire logic        has_position,
    input  wire logic [47:0] grid_text,
    input  wire logic [31:0] latitude_word,
    input  wire logic [31:0] longitude_word,
    input  wire logic [6:0]  dump_limit,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      out_key_high,
    output logic [63:0]      out_key_low,
    output logic [31:0]      out_heard_time,
    output logic [31:0]      out_freq_hz,
    output logic signed [7:0] out_snr_db,
    output logic [63:0]      out_mode_text,
    output logic             out_has_position,
    output logic [47:0]      out_grid_text,
    output logic [31:0]      out_latitude_word,
    output logic [31:0]      out_longitude_word,
    output logic             last_entry,
    output logic             table_empty
);

    typedef enum logic [2:0] {S_IDLE, S_PACK, S_WRITE, S_DUMP, S_EMPTY} state_t;

    state_t state_reg;
    logic [31:0] ttl_reg;
    logic [CNT_W-1:0] count_reg, kept_reg, step_reg, sent_reg, lim_reg, rot_reg;
    logic [IDX_W-1:0] slot_reg, best_idx_reg;
    logic found_reg, is_add_reg;
    logic [31:0] best_reg;
    rec_t in_reg;
    rec_t out_rec_reg;
    logic out_valid_reg, last_reg, empty_reg;

    cell_cmd_t cmd;
    rec_t wr_rec;
    rec_t cell_rec [CAPACITY];
    logic [CAPACITY-1:0] sel;

    // records shift toward cell 0; cell 0 feeds the tail
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            akst_cell u_cell (
                .clk(clk), .cmd(cmd), .sel(sel[g]),
                .wr_rec(wr_rec), .nb_rec(cell_rec[(g + 1) % CAPACITY]),
                .rec(cell_rec[g])
            );
        end
    endgenerate

    logic out_free;
    logic dump_go;
    logic out_load;
    logic [IDX_W-1:0] tail_sel;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    // last held cell, the place where a kept head record goes back in
    assign tail_sel = IDX_W'(count_reg - 1'b1);
    assign dump_go = (rot_reg != '0) && ((sent_reg == lim_reg) || out_free);
    assign out_load = ((state_reg == S_DUMP) && dump_go && (sent_reg != lim_reg)) ||
                      ((state_reg == S_EMPTY) && out_free);

    logic head_keep, head_match;
    logic [31:0] head_age;
    assign head_age = in_reg.heard - cell_rec[0].heard;
    assign head_keep = (in_reg.heard < cell_rec[0].heard) || (head_age <= ttl_reg);
    assign head_match = (cell_rec[0].key_high == in_reg.key_high) &&
                        (cell_rec[0].key_low == in_reg.key_low);

    always_comb
    begin
        cmd = '0;
        sel = '0;
        wr_rec = cell_rec[0];
        unique case (state_reg)
            S_PACK:
            begin
                if (step_reg != '0)
                begin
                    cmd.shift = 1'b1;
                    if (head_keep)
                    begin
                        cmd.write = 1'b1;
                        sel[tail_sel] = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (dump_go)
                begin
                    cmd.shift = 1'b1;
                    cmd.write = 1'b1;
                    sel[tail_sel] = 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                sel[slot_reg] = 1'b1;
                wr_rec = in_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ttl_reg   <= TTL_RESET;
            count_reg <= '0;
            kept_reg  <= '0;
            step_reg  <= '0;
            sent_reg  <= '0;
            lim_reg   <= '0;
            rot_reg   <= '0;
            slot_reg  <= '0;
            best_idx_reg <= '0;
            found_reg <= 1'b0;
            is_add_reg <= 1'b0;
            best_reg  <= '0;
            out_rec_reg <= '0;
            out_valid_reg <= 1'b0;
            last_reg <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_rec_reg <= (state_reg == S_EMPTY) ? '0 : cell_rec[0];
                last_reg <= (state_reg == S_EMPTY) ||
                            (CNT_W'(sent_reg + 1'b1) == lim_reg);
                empty_reg <= (state_reg == S_EMPTY);
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        ttl_reg <= cfg_data;
                    if (in_valid)
                    begin
                        is_add_reg <= (op == OP_ADD);
                        lim_reg <= (dump_limit > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) :
                                   CNT_W'(dump_limit);
                        step_reg <= count_reg;
                        kept_reg <= '0;
                        sent_reg <= '0;
                        found_reg <= 1'b0;
                        unique case (op)
                            OP_CLEAR: count_reg <= '0;
                            OP_ADD, OP_DUMP: state_reg <= S_PACK;
                            default: ;
                        endcase
                    end
                end
                S_PACK:
                begin
                    if (step_reg == '0)
                    begin
                        if (is_add_reg)
                        begin
                            state_reg <= S_WRITE;
                            if (!found_reg)
                            begin
                                if (count_reg < CNT_W'(CAPACITY))
                                begin
                                    slot_reg <= count_reg[IDX_W-1:0];
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                    slot_reg <= best_idx_reg;
                            end
                        end
                        else
                        begin
                            lim_reg <= (count_reg < lim_reg) ? count_reg : lim_reg;
                            rot_reg <= count_reg;
                            state_reg <= (count_reg == '0 || lim_reg == '0) ? S_EMPTY : S_DUMP;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                        if (head_keep)
                        begin
                            kept_reg <= kept_reg + 1'b1;
                            if (!found_reg && head_match)
                            begin
                                found_reg <= 1'b1;
                                slot_reg <= kept_reg[IDX_W-1:0];
                            end
                            // strict compare keeps the lowest index on ties
                            if (kept_reg == '0 || cell_rec[0].heard < best_reg)
                            begin
                                best_reg <= cell_rec[0].heard;
                                best_idx_reg <= kept_reg[IDX_W-1:0];
                            end
                        end
                        else
                            count_reg <= count_reg - 1'b1;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_DUMP:
                begin
                    if (rot_reg == '0)
                        state_reg <= S_IDLE;
                    else if (dump_go)
                    begin
                        rot_reg <= rot_reg - 1'b1;
                        if (sent_reg != lim_reg)
                            sent_reg <= sent_reg + 1'b1;
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign last_entry = last_reg;
    assign table_empty = empty_reg;
    assign out_key_high = out_rec_reg.key_high;
    assign out_key_low = out_rec_reg.key_low;
    assign out_heard_time = out_rec_reg.heard;
    assign out_freq_hz = out_rec_reg.freq;
    assign out_snr_db = out_rec_reg.snr;
    assign out_mode_text = out_rec_reg.mode;
    assign out_has_position = out_rec_reg.pos;
    assign out_grid_text = out_rec_reg.grid;
    assign out_latitude_word = out_rec_reg.lat;
    assign out_longitude_word = out_rec_reg.lon;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            in_reg <= '{key_high, key_low, now_time, freq_hz, snr_db, mode_text,
                        has_position, grid_text, latitude_word, longitude_word};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(CAPACITY))) else $error("count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (in_stall && !cfg_ready)) else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        table_empty && out_valid |-> last_entry) else $error("empty marker not last");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_rec_reg) &&
        $stable({last_reg, empty_reg})) else $error("stalled result changed");

endmodule

`default_nettype wire
